>>> hw/rtl/rse_pkg.sv
package rse_pkg;

    // Architectural sizes.
    localparam int XLEN    = 64;
    localparam int NUM_REG = 32;
    localparam int REG_AW  = $clog2(NUM_REG);

    // Program counter value after reset.
    localparam logic [XLEN-1:0] START_PC_RESET = 64'h0000_0000_8000_0000;

    // Register that ebreak reports as the trap value.
    localparam logic [REG_AW-1:0] REG_A0 = 5'd10;

    // Item commands.
    localparam logic CMD_EXEC      = 1'b0;
    localparam logic CMD_LOAD_DATA = 1'b1;

    // Major opcodes.
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_OPW    = 7'h3B;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_OPIMMW = 7'h1B;

    // funct3 and funct7 codes.
    localparam logic [2:0] F3_ADD   = 3'd0;
    localparam logic [2:0] F3_BEQ   = 3'd0;
    localparam logic [2:0] F3_JALR  = 3'd0;
    localparam logic [2:0] F3_BNE   = 3'd1;
    localparam logic [2:0] F3_WORD  = 3'd2;
    localparam logic [2:0] F3_DWORD = 3'd3;
    localparam logic [2:0] F3_SLTIU = 3'd3;
    localparam logic [6:0] F7_ZERO  = 7'h00;
    localparam logic [6:0] F7_SUB   = 7'h20;

    // The one system word that is recognised.
    localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

    // Memory request codes and sizes.
    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;
    localparam logic [3:0] BYTES_NONE  = 4'd0;
    localparam logic [3:0] BYTES_WORD  = 4'd4;
    localparam logic [3:0] BYTES_DWORD = 4'd8;

    // Result status codes.
    localparam logic [2:0] ST_EXECUTED  = 3'd0;
    localparam logic [2:0] ST_EBREAK    = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_LOAD_WAIT = 3'd3;
    localparam logic [2:0] ST_LOAD_DONE = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;
    localparam logic [2:0] ST_HALTED    = 3'd6;

    // Architectural state apart from the register file.
    typedef struct packed {
        logic [XLEN-1:0]   pc;
        logic              load_pending;
        logic [REG_AW-1:0] load_dest;
        logic              load_is_word;
        logic              halted;
    } t_arch;

    // Register file write.
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_wb;

    // One result item.
    typedef struct packed {
        logic [XLEN-1:0] instruction_pc;
        logic [XLEN-1:0] next_pc;
        logic [1:0]      mem_request;
        logic [XLEN-1:0] mem_address;
        logic [3:0]      mem_bytes;
        logic [XLEN-1:0] mem_write_data;
        logic [2:0]      status;
        logic [XLEN-1:0] trap_value;
    } t_result;

endpackage

>>> hw/rtl/rse_regfile.sv
module rse_regfile
    import rse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [REG_AW-1:0] i_rd_addr1,
    input  logic [REG_AW-1:0] i_rd_addr2,
    input  t_wb               i_wb,
    output logic [XLEN-1:0]   o_rd_data1,
    output logic [XLEN-1:0]   o_rd_data2,
    output logic [XLEN-1:0]   o_a0
);

    logic [XLEN-1:0]    r_mem [NUM_REG];
    logic [NUM_REG-1:0] r_valid;
    logic [XLEN-1:0]    r_q1;
    logic [XLEN-1:0]    r_q2;
    logic [XLEN-1:0]    r_a0;

    // Storage array; writes to x0 never arrive here.
    always_ff @(posedge i_clk) begin
        if (i_wb.en) begin
            r_mem[i_wb.addr] <= i_wb.data;
        end
    end

    // Valid bits make every entry read as zero until it is first written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wb.en) begin
            r_valid[i_wb.addr] <= 1'b1;
        end
    end

    // Registered read ports, with the write of the same edge passed straight through.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wb.en && i_wb.addr == i_rd_addr1) begin
                r_q1 <= i_wb.data;
            end else if (r_valid[i_rd_addr1]) begin
                r_q1 <= r_mem[i_rd_addr1];
            end else begin
                r_q1 <= '0;
            end
            if (i_wb.en && i_wb.addr == i_rd_addr2) begin
                r_q2 <= i_wb.data;
            end else if (r_valid[i_rd_addr2]) begin
                r_q2 <= r_mem[i_rd_addr2];
            end else begin
                r_q2 <= '0;
            end
        end
    end

    // Copy of a0 for the ebreak trap value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a0 <= '0;
        end else if (i_wb.en && i_wb.addr == REG_A0) begin
            r_a0 <= i_wb.data;
        end
    end

    assign o_rd_data1 = r_q1;
    assign o_rd_data2 = r_q2;
    assign o_a0       = r_a0;

endmodule

>>> hw/rtl/rse_exec.sv
module rse_exec
    import rse_pkg::*;
(
    input  logic            i_cmd,
    input  logic [31:0]     i_instr,
    input  logic [XLEN-1:0] i_ldata,
    input  logic [XLEN-1:0] i_rs1_data,
    input  logic [XLEN-1:0] i_rs2_data,
    input  logic [XLEN-1:0] i_a0,
    input  t_arch           i_arch,
    output t_result         o_res,
    output t_wb             o_wb,
    output t_arch           o_arch_next
);

    logic [6:0]        opc;
    logic [2:0]        f3;
    logic [6:0]        f7;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_s;
    logic [XLEN-1:0]   imm_b;
    logic [XLEN-1:0]   imm_u;
    logic [XLEN-1:0]   imm_j;
    logic [XLEN-1:0]   pc_plus4;
    logic [XLEN-1:0]   sum_ai;
    logic [XLEN-1:0]   sum_ab;
    logic [XLEN-1:0]   diff_ab;
    logic [XLEN-1:0]   npc;
    t_wb               wb;

    // Instruction fields and immediates.
    assign opc   = i_instr[6:0];
    assign f3    = i_instr[14:12];
    assign f7    = i_instr[31:25];
    assign rd    = i_instr[11:7];
    assign imm_i = {{52{i_instr[31]}}, i_instr[31:20]};
    assign imm_s = {{52{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b = {{51{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                    i_instr[11:8], 1'b0};
    assign imm_u = {{32{i_instr[31]}}, i_instr[31:12], 12'b0};
    assign imm_j = {{43{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                    i_instr[30:21], 1'b0};

    // Adders; pc_plus4 and sum_ai are shared between instruction forms.
    assign pc_plus4 = i_arch.pc + XLEN'(4);
    assign sum_ai   = i_rs1_data + imm_i;
    assign sum_ab   = i_rs1_data + i_rs2_data;
    assign diff_ab  = i_rs1_data - i_rs2_data;

    // Decode and execute; the instruction forms are tried in a fixed order.
    always_comb begin
        o_res                = '0;
        o_res.instruction_pc = i_arch.pc;
        o_arch_next          = i_arch;
        wb                   = '0;
        wb.addr              = rd;
        npc                  = i_arch.pc;

        if (i_arch.halted) begin
            o_res.status = ST_HALTED;
        end else if (i_cmd == CMD_LOAD_DATA) begin
            if (!i_arch.load_pending) begin
                o_res.status = ST_IGNORED;
            end else begin
                wb.en   = 1'b1;
                wb.addr = i_arch.load_dest;
                wb.data = i_arch.load_is_word ? {{32{i_ldata[31]}}, i_ldata[31:0]} : i_ldata;
                o_arch_next.load_pending = 1'b0;
                o_res.instruction_pc     = i_arch.pc - XLEN'(4);
                o_res.status             = ST_LOAD_DONE;
            end
        end else if (i_arch.load_pending) begin
            o_res.status = ST_IGNORED;
        end else begin
            npc          = pc_plus4;
            o_res.status = ST_EXECUTED;
            priority if (opc == OPC_AUIPC) begin
                wb.en   = 1'b1;
                wb.data = i_arch.pc + imm_u;
            end else if (opc == OPC_LOAD && (f3 == F3_DWORD || f3 == F3_WORD)) begin
                o_arch_next.load_pending = 1'b1;
                o_arch_next.load_dest    = rd;
                o_arch_next.load_is_word = (f3 == F3_WORD);
                o_res.mem_request        = MEM_READ;
                o_res.mem_address        = sum_ai;
                o_res.mem_bytes          = (f3 == F3_WORD) ? BYTES_WORD : BYTES_DWORD;
                o_res.status             = ST_LOAD_WAIT;
            end else if (opc == OPC_STORE && f3 == F3_DWORD) begin
                o_res.mem_request    = MEM_WRITE;
                o_res.mem_address    = i_rs1_data + imm_s;
                o_res.mem_bytes      = BYTES_DWORD;
                o_res.mem_write_data = i_rs2_data;
            end else if (opc == OPC_OPIMM && f3 == F3_ADD) begin
                wb.en   = 1'b1;
                wb.data = sum_ai;
            end else if (opc == OPC_JAL) begin
                wb.en   = 1'b1;
                wb.data = pc_plus4;
                npc     = i_arch.pc + imm_j;
            end else if (opc == OPC_JALR && f3 == F3_JALR) begin
                wb.en   = 1'b1;
                wb.data = pc_plus4;
                npc     = {sum_ai[XLEN-1:1], 1'b0};
            end else if (opc == OPC_OPW && f3 == F3_ADD && f7 == F7_ZERO) begin
                wb.en   = 1'b1;
                wb.data = {{32{sum_ab[31]}}, sum_ab[31:0]};
            end else if (opc == OPC_OP && f3 == F3_ADD && f7 == F7_SUB) begin
                wb.en   = 1'b1;
                wb.data = diff_ab;
            end else if (opc == OPC_OPIMM && f3 == F3_SLTIU) begin
                wb.en   = 1'b1;
                wb.data = {{(XLEN-1){1'b0}}, (i_rs1_data < imm_i)};
            end else if (opc == OPC_BRANCH && f3 == F3_BNE) begin
                if (i_rs1_data != i_rs2_data) begin
                    npc = i_arch.pc + imm_b;
                end
            end else if (opc == OPC_BRANCH && f3 == F3_BEQ) begin
                if (i_rs1_data == i_rs2_data) begin
                    npc = i_arch.pc + imm_b;
                end
            end else if (opc == OPC_OPIMMW && f3 == F3_ADD) begin
                wb.en   = 1'b1;
                wb.data = {{32{sum_ai[31]}}, sum_ai[31:0]};
            end else if (i_instr == EBREAK_WORD) begin
                o_res.trap_value   = i_a0;
                o_arch_next.halted = 1'b1;
                o_res.status       = ST_EBREAK;
            end else begin
                o_arch_next.halted = 1'b1;
                o_res.status       = ST_INVALID;
            end
            o_arch_next.pc = npc;
        end

        // x0 is never written.
        if (wb.addr == '0) begin
            wb.en = 1'b0;
        end
        o_res.next_pc = npc;
        o_wb          = wb;
    end

endmodule

>>> hw/rtl/rv64_subset_instruction_executor.sv
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_command, i_instruction, i_load_data
// out       output     o_out_valid / i_out_stall o_instruction_pc ... o_trap_value
// cfg       input      i_cfg_we                  i_cfg_wdata (start_pc)
//
// The accepting edge loads the instruction register and reads the register file into
// the operand registers; the item then executes into the result register, which
// presents the result, once that register is free.
// A new item is accepted in every cycle unless the output stalls; the register file
// read port and the single execute stage set that rate, bypassing a same-edge write.
// Reset is synchronous and clears the register file valid bits, the load and halt
// flags and both stages, and loads the pc with 0x80000000.
// A stall on the output holds the result register, then the execute stage, then the input.
module rv64_subset_instruction_executor
    import rse_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_command,
    input  logic [31:0]     i_instruction,
    input  logic [XLEN-1:0] i_load_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [XLEN-1:0] o_instruction_pc,
    output logic [XLEN-1:0] o_next_pc,
    output logic [1:0]      o_mem_request,
    output logic [XLEN-1:0] o_mem_address,
    output logic [3:0]      o_mem_bytes,
    output logic [XLEN-1:0] o_mem_write_data,
    output logic [2:0]      o_status,
    output logic [XLEN-1:0] o_trap_value,
    input  logic            i_cfg_we,
    input  logic [XLEN-1:0] i_cfg_wdata
);

    logic            r_e_valid;
    logic            r_e_cmd;
    logic [31:0]     r_e_instr;
    logic [XLEN-1:0] r_e_ldata;
    logic            r_o_valid;
    t_result         r_out;
    t_arch           r_arch;
    logic [XLEN-1:0] r_start_pc;
    t_arch           n_arch;
    t_result         res;
    t_wb             wb;
    t_wb             wb_commit;
    logic            in_accept;
    logic            e_advance;
    logic [XLEN-1:0] rs1_data;
    logic [XLEN-1:0] rs2_data;
    logic [XLEN-1:0] a0_data;

    // Handshake: the execute stage moves on whenever the result register is free.
    assign e_advance  = r_e_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_e_valid && !e_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Boot address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc <= START_PC_RESET;
        end else if (i_cfg_we) begin
            r_start_pc <= i_cfg_wdata;
        end
    end

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (in_accept) begin
            r_e_valid <= 1'b1;
        end else if (e_advance) begin
            r_e_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_e_cmd   <= i_command;
            r_e_instr <= i_instruction;
            r_e_ldata <= i_load_data;
        end
    end

    // Register file, read as the item is accepted.
    assign wb_commit = '{en: wb.en && e_advance, addr: wb.addr, data: wb.data};

    rse_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_addr1 (i_instruction[19:15]),
        .i_rd_addr2 (i_instruction[24:20]),
        .i_wb       (wb_commit),
        .o_rd_data1 (rs1_data),
        .o_rd_data2 (rs2_data),
        .o_a0       (a0_data)
    );

    // Execute.
    rse_exec u_exec (
        .i_cmd       (r_e_cmd),
        .i_instr     (r_e_instr),
        .i_ldata     (r_e_ldata),
        .i_rs1_data  (rs1_data),
        .i_rs2_data  (rs2_data),
        .i_a0        (a0_data),
        .i_arch      (r_arch),
        .o_res       (res),
        .o_wb        (wb),
        .o_arch_next (n_arch)
    );

    // Architectural state commits as the item leaves the execute stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arch.pc           <= START_PC_RESET;
            r_arch.load_pending <= 1'b0;
            r_arch.load_dest    <= '0;
            r_arch.load_is_word <= 1'b0;
            r_arch.halted       <= 1'b0;
        end else if (e_advance) begin
            r_arch <= n_arch;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (e_advance) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_instruction_pc = r_out.instruction_pc;
    assign o_next_pc        = r_out.next_pc;
    assign o_mem_request    = r_out.mem_request;
    assign o_mem_address    = r_out.mem_address;
    assign o_mem_bytes      = r_out.mem_bytes;
    assign o_mem_write_data = r_out.mem_write_data;
    assign o_status         = r_out.status;
    assign o_trap_value     = r_out.trap_value;

`ifndef NO_ASSERTIONS
    // A pending load and a halt exclude each other.
    a_pending_not_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_arch.load_pending && r_arch.halted))
        else $error("load pending while halted");

    // The register file never sees a write to x0.
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wb_commit.en |-> wb_commit.addr != '0)
        else $error("write to x0 reached the register file");

    // An issued load leaves the core waiting for its data.
    a_load_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_advance && res.status == ST_LOAD_WAIT) |=> r_arch.load_pending)
        else $error("load issued without pending flag");

    // The pc leaves reset at the boot address.
    a_reset_pc: assert property (@(posedge i_clk)
        !i_rst_n |=> r_arch.pc == r_start_pc)
        else $error("pc not at boot address after reset");
`endif

endmodule
